@@ design/ir_cliff_trimmed_mean_detector_defines.svh @@
// Assertion macros shared by the cliff detector modules.
`ifndef IR_CLIFF_TRIMMED_MEAN_DETECTOR_DEFINES_SVH
`define IR_CLIFF_TRIMMED_MEAN_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define CTMD_ASSERT_IMP(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("ctmd assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define CTMD_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("ctmd assertion failed");

`endif

@@ design/ctmd_pkg.sv @@
package ctmd_pkg;

    // Fixed field widths.
    localparam int SAMPLE_BITS = 12;
    localparam int CH_W        = 2;
    localparam int FLAG_W      = 3;
    localparam int THR_W       = 12;
    localparam int FS_W        = 13;
    localparam int DIFF_W      = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 13;

    // Default structure of the filter.
    localparam int WINDOW_DEF     = 32;
    localparam int TRIM_FIRST_DEF = 14;
    localparam int TRIM_END_DEF   = 18;
    localparam int SENSORS_DEF    = 3;

    // Register reset values and the result ceiling.
    localparam logic [THR_W-1:0]  THR_RESET = 12'd30;
    localparam logic [FS_W-1:0]   FS_RESET  = 13'd3300;
    localparam logic [DIFF_W-1:0] DIFF_MAX  = 13'h1FFF;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE = 1'b1;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic [CH_W-1:0]        channel;
        logic                   emitter_on;
    } item_t;

    typedef struct packed {
        logic [CH_W-1:0]   done_channel;
        logic [DIFF_W-1:0] diff_mv;
        logic [FLAG_W-1:0] danger_flags;
    } result_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_CMP,
        S_SUM_RD,
        S_SUM_ACC,
        S_POST,
        S_MUL,
        S_DIV_GO,
        S_DIV,
        S_OUT
    } state_t;

endpackage

@@ design/ctmd_ram.sv @@
module ctmd_ram
    import ctmd_pkg::*;
#(
    parameter int WIDTH = SAMPLE_BITS,
    parameter int DEPTH = WINDOW_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ design/ctmd_div.sv @@
`include "ir_cliff_trimmed_mean_detector_defines.svh"

module ctmd_div
    import ctmd_pkg::*;
#(
    parameter int DIVISOR = TRIM_END_DEF - TRIM_FIRST_DEF,
    parameter int DW      = 15
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    output logic          done,
    output logic [DW-1:0] quotient
);

    // Division by a constant as a multiply by its rounded-up reciprocal. With the
    // shift set to DW plus the ceiling log2 of the divisor, the upper product bits
    // give the exact floor quotient for every dividend below 2^DW.
    localparam int     LOG_D  = $clog2(DIVISOR);
    localparam int     SHIFT  = DW + LOG_D;
    localparam int     RCP_W  = DW + 2;
    localparam int     PROD_W = SHIFT + DW;
    localparam longint RCP_L  =
        ((longint'(1) << SHIFT) + longint'(DIVISOR) - 1) / longint'(DIVISOR);
    localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);

    logic              done_reg;
    logic [DW-1:0]     quo_reg;
    logic [PROD_W-1:0] prod;

    // Reciprocal product of the dividend.
    assign prod = PROD_W'(dividend) * PROD_W'(RCP);

    // The quotient is ready in the cycle after start.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= prod[SHIFT +: DW];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    // Every start is answered by done on the next cycle.
    `CTMD_ASSERT_NEXT(a_done_after_start, clk, rst_n, start, done_reg)
    // A new division is never started while a quotient is being handed over.
    `CTMD_ASSERT_IMP(a_no_overlap, clk, rst_n, start, !done_reg)
    // Done lasts a single cycle.
    `CTMD_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)

endmodule

@@ design/ir_cliff_trimmed_mean_detector.sv @@
// Channel   Direction  Handshake            Payload
// item      in         item_valid/stall     item_t: sample, channel, emitter_on
// result    out        result_valid/stall   result_t: done_channel, diff_mv, danger_flags
// cfg       in         cfg_we               cfg_index, cfg_data
//
// An item walks down the sorted store in read and compare steps paced by its single read
// port, moving larger samples up a place; items on channels >= SENSORS are ignored.
// A completed window then reads and adds each middle rank and stores a lit sum, or for a
// dark window forms the difference, multiplies, reciprocal-divides and loads the output.
// All control state clears at once on reset; the sorted store needs no clearing.
// Input waits on a result only while a finished dark window finds the output full and stalled.
`include "ir_cliff_trimmed_mean_detector_defines.svh"

module ir_cliff_trimmed_mean_detector
    import ctmd_pkg::*;
#(
    parameter int WINDOW     = WINDOW_DEF,
    parameter int TRIM_FIRST = TRIM_FIRST_DEF,
    parameter int TRIM_END   = TRIM_END_DEF,
    parameter int SENSORS    = SENSORS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  item_t                 item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int ADDR_W     = $clog2(WINDOW);
    localparam int TRIM_COUNT = (TRIM_END > TRIM_FIRST) ? (TRIM_END - TRIM_FIRST) : 1;
    localparam int SUM_HI     = (TRIM_END > WINDOW) ? WINDOW : TRIM_END;
    localparam bit SUM_EMPTY  = (SUM_HI <= TRIM_FIRST);
    localparam int SUM_W      = SAMPLE_BITS + $clog2(TRIM_COUNT);
    localparam int PROD_W     = SUM_W + FS_W;
    localparam int QUO_W      = PROD_W - SAMPLE_BITS;
    localparam logic [ADDR_W-1:0] SUM_LO_A   = ADDR_W'(SUM_EMPTY ? 0 : TRIM_FIRST);
    localparam logic [ADDR_W-1:0] SUM_LAST_A = ADDR_W'(SUM_EMPTY ? 0 : SUM_HI - 1);
    localparam logic [ADDR_W-1:0] FILL_LAST  = ADDR_W'(WINDOW - 1);

    state_t                 state_reg, state_next;
    logic [THR_W-1:0]       thr_reg;
    logic [FS_W-1:0]        fs_reg;
    logic [ADDR_W-1:0]      fill_reg, fill_next;
    logic [CH_W-1:0]        wch_reg, wch_next;
    logic                   wph_reg, wph_next;
    logic [ADDR_W-1:0]      pos_reg, pos_next;
    logic [ADDR_W-1:0]      rank_reg, rank_next;
    logic [SUM_W-1:0]       lit_reg [SENSORS];
    logic [SUM_W-1:0]       lit_next [SENSORS];
    logic [FLAG_W-1:0]      flags_reg, flags_next;
    logic                   res_valid_reg, res_valid_next;
    logic [SAMPLE_BITS-1:0] smp_reg, smp_next;
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic                   ph_reg, ph_next;
    logic [SUM_W-1:0]       acc_reg, acc_next;
    logic [PROD_W-1:0]      prod_reg, prod_next;
    logic [DIFF_W-1:0]      mv_reg, mv_next;
    result_t                res_reg, res_next;

    logic                   in_acc;
    logic                   ch_ok;
    logic                   slot_free;
    logic                   gt;
    logic                   ins_done;
    logic [SUM_W-1:0]       lit_cur;
    logic [SUM_W-1:0]       diff;
    logic [DIFF_W-1:0]      mv_sat;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   div_start;
    logic                   div_done;
    logic [QUO_W-1:0]       div_quo;

    // Sorted sample store.
    ctmd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Scaling divider: the product over 2^SAMPLE_BITS, then over the trim count.
    ctmd_div #(
        .DIVISOR (TRIM_COUNT),
        .DW      (QUO_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg[PROD_W-1:SAMPLE_BITS]),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Handshake and status terms.
    assign in_acc    = item_valid && !item_stall;
    assign ch_ok     = (32'(item.channel) < SENSORS);
    assign slot_free = !res_valid_reg || !result_stall;
    assign gt        = (ram_rdata > smp_reg);
    assign ins_done  = ((state_reg == S_INS_RD) && (pos_reg == '0))
                    || ((state_reg == S_INS_CMP) && !gt);

    // Lit sum of the current channel and the absolute difference.
    always_comb
    begin
        lit_cur = '0;
        for (int i = 0; i < SENSORS; i++)
        begin
            if (32'(ch_reg) == i)
            begin
                lit_cur = lit_reg[i];
            end
        end
    end

    assign diff   = (acc_reg >= lit_cur) ? (acc_reg - lit_cur) : (lit_cur - acc_reg);
    assign mv_sat = (div_quo > QUO_W'(DIFF_MAX)) ? DIFF_MAX : div_quo[DIFF_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && ch_ok)
                begin
                    state_next = S_INS_RD;
                end
            end
            S_INS_RD, S_INS_CMP:
            begin
                if (ins_done)
                begin
                    if (fill_reg != FILL_LAST)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (SUM_EMPTY)
                    begin
                        state_next = S_POST;
                    end
                    else
                    begin
                        state_next = S_SUM_RD;
                    end
                end
                else if (state_reg == S_INS_RD)
                begin
                    state_next = S_INS_CMP;
                end
                else
                begin
                    state_next = S_INS_RD;
                end
            end
            S_SUM_RD:
            begin
                state_next = S_SUM_ACC;
            end
            S_SUM_ACC:
            begin
                state_next = (rank_reg == SUM_LAST_A) ? S_POST : S_SUM_RD;
            end
            S_POST:
            begin
                state_next = ph_reg ? S_IDLE : S_MUL;
            end
            S_MUL:
            begin
                state_next = S_DIV_GO;
            end
            S_DIV_GO:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State outputs: store port, divider start, input stall.
    always_comb
    begin
        ram_we     = 1'b0;
        ram_waddr  = pos_reg;
        ram_wdata  = smp_reg;
        ram_raddr  = pos_reg - 1'b1;
        div_start  = 1'b0;
        item_stall = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                item_stall = 1'b0;
            end
            S_INS_RD:
            begin
                ram_we = (pos_reg == '0);
            end
            S_INS_CMP:
            begin
                ram_we    = 1'b1;
                ram_wdata = gt ? ram_rdata : smp_reg;
            end
            S_SUM_RD:
            begin
                ram_raddr = rank_reg;
            end
            S_DIV_GO:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                item_stall = 1'b1;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        fill_next      = fill_reg;
        wch_next       = wch_reg;
        wph_next       = wph_reg;
        pos_next       = pos_reg;
        rank_next      = rank_reg;
        flags_next     = flags_reg;
        smp_next       = smp_reg;
        ch_next        = ch_reg;
        ph_next        = ph_reg;
        acc_next       = acc_reg;
        prod_next      = prod_reg;
        mv_next        = mv_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && result_stall;
        for (int i = 0; i < SENSORS; i++)
        begin
            lit_next[i] = lit_reg[i];
        end

        // Take an item; a change of channel or phase drops the partial window.
        if ((state_reg == S_IDLE) && in_acc && ch_ok)
        begin
            smp_next = item.sample;
            ch_next  = item.channel;
            ph_next  = item.emitter_on;
            if ((fill_reg == '0) || (item.channel != wch_reg)
                || (item.emitter_on != wph_reg))
            begin
                fill_next = '0;
                pos_next  = '0;
                wch_next  = item.channel;
                wph_next  = item.emitter_on;
            end
            else
            begin
                pos_next = fill_reg;
            end
        end

        // Insertion walk: move larger entries up one place.
        if ((state_reg == S_INS_CMP) && gt)
        begin
            pos_next = pos_reg - 1'b1;
        end
        if (ins_done)
        begin
            if (fill_reg == FILL_LAST)
            begin
                fill_next = '0;
                rank_next = SUM_LO_A;
                acc_next  = '0;
            end
            else
            begin
                fill_next = fill_reg + 1'b1;
            end
        end

        // Trimmed sum over the middle ranks.
        if (state_reg == S_SUM_ACC)
        begin
            acc_next  = acc_reg + SUM_W'(ram_rdata);
            rank_next = rank_reg + 1'b1;
        end

        // Lit window stores its sum; dark window forms the difference.
        if (state_reg == S_POST)
        begin
            if (ph_reg)
            begin
                for (int i = 0; i < SENSORS; i++)
                begin
                    if (32'(ch_reg) == i)
                    begin
                        lit_next[i] = acc_reg;
                    end
                end
            end
            else
            begin
                acc_next = diff;
            end
        end

        if (state_reg == S_MUL)
        begin
            prod_next = PROD_W'(acc_reg) * PROD_W'(fs_reg);
        end

        // Scaled difference and danger bit.
        if ((state_reg == S_DIV) && div_done)
        begin
            mv_next = mv_sat;
            for (int i = 0; i < FLAG_W; i++)
            begin
                if (32'(ch_reg) == i)
                begin
                    flags_next[i] = (mv_sat <= DIFF_W'(thr_reg));
                end
            end
        end

        // Hand the result to the output register.
        if ((state_reg == S_OUT) && slot_free)
        begin
            res_next.done_channel = ch_reg;
            res_next.diff_mv      = mv_reg;
            res_next.danger_flags = flags_reg;
            res_valid_next        = 1'b1;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
            fs_reg  <= FS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD:  thr_reg <= cfg_data[THR_W-1:0];
                CFG_FULL_SCALE: fs_reg  <= cfg_data[FS_W-1:0];
                default:        thr_reg <= thr_reg;
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            wch_reg       <= '0;
            wph_reg       <= 1'b0;
            pos_reg       <= '0;
            rank_reg      <= '0;
            flags_reg     <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < SENSORS; i++)
            begin
                lit_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            wch_reg       <= wch_next;
            wph_reg       <= wph_next;
            pos_reg       <= pos_next;
            rank_reg      <= rank_next;
            flags_reg     <= flags_next;
            res_valid_reg <= res_valid_next;
            for (int i = 0; i < SENSORS; i++)
            begin
                lit_reg[i] <= lit_next[i];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        smp_reg  <= smp_next;
        ch_reg   <= ch_next;
        ph_reg   <= ph_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        mv_reg   <= mv_next;
        res_reg  <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    // A result is loaded only from the output state, for the current channel.
    `CTMD_ASSERT_IMP(a_rise_from_out, clk, rst_n, $rose(res_valid_reg), $past(state_reg == S_OUT))
    `CTMD_ASSERT_NEXT(a_load_channel, clk, rst_n, (state_reg == S_OUT) && slot_free, res_valid_reg && (res_reg.done_channel == $past(ch_reg)))
    // The divider finishes only while the sequencer waits for it.
    `CTMD_ASSERT_IMP(a_div_done_wait, clk, rst_n, div_done, state_reg == S_DIV)

endmodule
